/* rtl/pcmrc_pkg.sv */
// shared types and constants of the pcm8 to pcm16 rate converter
`default_nettype none

package pcmrc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RATE_W    = 16;
  localparam int DIV_W     = RATE_W + FRAC_BITS;
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] MAX_FRAMES  = 6'd63;
  localparam logic [15:0]      VERSION_OK  = 16'd3;
  localparam logic [7:0]       SAMPLE_FLIP = 8'h80;
  localparam logic [31:0]      LIMIT_X1    = 32'hFFFF_FFFF >> 2;
  localparam logic [31:0]      LIMIT_X2    = 32'hFFFF_FFFF >> 3;
  localparam logic [31:0]      LIMIT_X4    = 32'hFFFF_FFFF >> 4;

  typedef enum logic [2:0] {
    KIND_FRAME       = 3'd0,
    KIND_HDR_OK      = 3'd1,
    KIND_BAD_VERSION = 3'd2,
    KIND_TOO_LONG    = 3'd3,
    KIND_RATE_LOW    = 3'd4,
    KIND_END         = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_GENERAL = 2'd0,
    MODE_X1      = 2'd1,
    MODE_X2      = 2'd2,
    MODE_X4      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_HEADER = 3'd1,
    S_CHECK  = 3'd2,
    S_DIVIDE = 3'd3,
    S_STATUS = 3'd4,
    S_DATA   = 3'd5,
    S_GEN    = 3'd6,
    S_END    = 3'd7
  } state_t;

  typedef struct packed {
    logic  hdr_first;
    logic  hdr_next;
    logic  div_start;
    logic  setup;
    logic  smp_load;
    logic  gen_step;
    logic  byte_done;
    logic  emit;
    kind_t emit_kind;
    logic  emit_last;
  } cmd_t;

  typedef struct packed {
    logic  hdr_idx_last;
    logic  hdr_bad_ver;
    logic  hdr_rate_low;
    logic  hdr_too_long;
    logic  count_zero;
    logic  div_done;
    mode_t mode;
    logic  acc_ge_one;
    logic  step_ge_one;
    logic  cnt_full;
    logic  cnt_last;
    logic  rep_last;
    logic  rem_one;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/pcmrc_byte_if.sv */
// input channel: one sound byte per word
`default_nettype none

interface pcmrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source(output valid, data_byte, start_req, input ready);
  modport sink(input valid, data_byte, start_req, output ready);
endinterface

`default_nettype wire

/* rtl/pcmrc_result_if.sv */
// output channel: one frame or status result per word
`default_nettype none

interface pcmrc_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] sample;
  logic               last;

  modport source(output valid, kind, sample, last, input ready);
  modport sink(input valid, kind, sample, last, output ready);
endinterface

`default_nettype wire

/* rtl/pcm8_to_pcm16_rate_converter.sv */
// top level of the pcm8 to pcm16 zero-order-hold rate converter
// data channel: one sound byte per word; start_req marks the first of eight
//   little-endian header bytes (version, rate, sample count) and aborts any
//   sound in progress; bytes with start_req low while idle are dropped
// result channel: header status, then one 16-bit frame word per output
//   sample, then an end word; last flags the final word caused by a byte
// header bytes are taken one per cycle; after the eighth byte the header is
//   checked in S_CHECK and the step of rate / OUT_RATE comes from a
//   reciprocal multiply in S_DIVIDE, then the status word is issued from
//   S_STATUS; a rejected header skips S_DIVIDE
// a sample byte is accepted in S_DATA and gives 1, 2 or 4 frame words at
//   OUT_RATE, OUT_RATE/2, OUT_RATE/4; other rates step a 2.16 accumulator
//   (default OUT_RATE), one frame per cycle while the output is free, then
//   close the byte; the end word follows the last sample
// reset returns the controller to idle and empties the output register
// a stalled receiver holds the output word; the controller waits for the
//   output register before issuing the next word and takes no byte meanwhile
`default_nettype none

module pcm8_to_pcm16_rate_converter import pcmrc_pkg::*; #(
  parameter int unsigned MIN_RATE = 700,
  parameter int unsigned OUT_RATE = 44100
) (
  input  wire logic       clk,
  input  wire logic       rst,
  pcmrc_byte_if.sink      data,
  pcmrc_result_if.source  result
);

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t sts;

  pcmrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (data.valid),
    .in_start (data.start_req),
    .in_ready (data.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  pcmrc_dp #(
    .MIN_RATE (MIN_RATE),
    .OUT_RATE (OUT_RATE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data.data_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_kind   (result.kind),
    .out_sample (result.sample),
    .out_last   (result.last)
  );

`ifndef SYNTHESIS
  // never load a word over one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("word issued onto a full output register");

  // an end word always closes its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.kind == KIND_END)) |-> result.last)
    else $error("end word without last");

  // status words carry a zero sample
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.kind != KIND_FRAME)) |-> (result.sample == 16'sd0))
    else $error("status word with non-zero sample");
`endif

endmodule

`default_nettype wire

/* rtl/pcmrc_div.sv */
// divider by a constant: reciprocal multiply, quotient and done registered in the cycle after start
`default_nettype none

module pcmrc_div import pcmrc_pkg::*; #(
  parameter int unsigned DIVISOR = 44100
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RATE_W-1:0] rate,
  output logic                   done,
  output logic [DIV_W-1:0]       quotient
);

  // floor((rate << FRAC_BITS) / DIVISOR) as (rate * RECIP) >> SHIFT,
  // exact while 2**SHIFT covers the largest rate times DIVISOR
  localparam longint unsigned SPAN   = 64'(DIVISOR) << RATE_W;
  localparam int              SHIFT  = $clog2(SPAN);
  localparam longint unsigned RECIP  =
    ((64'd1 << (FRAC_BITS + SHIFT)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam int              REC_W  = $clog2(RECIP + 64'd1);
  localparam int              PROD_W = RATE_W + REC_W;
  localparam logic [REC_W-1:0] RECIP_V = REC_W'(RECIP);

  logic [PROD_W-1:0] product;

  assign product = PROD_W'(rate) * PROD_W'(RECIP_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= DIV_W'(product >> SHIFT);
    end
  end

endmodule

`default_nettype wire

/* rtl/pcmrc_dp.sv */
// datapath: header register, decode, step accumulator, counters and output register
`default_nettype none

module pcmrc_dp import pcmrc_pkg::*; #(
  parameter int unsigned MIN_RATE = 700,
  parameter int unsigned OUT_RATE = 44100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire cmd_t        cmd,
  output status_t          sts,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic signed [15:0] out_sample,
  output logic             out_last
);

  localparam longint unsigned QUO_MAX =
    (((64'd1 << RATE_W) - 64'd1) << FRAC_BITS) / OUT_RATE;
  localparam int INC_W = $clog2(QUO_MAX + 2);
  localparam int ACC_W = ((INC_W > FRAC_BITS) ? INC_W : FRAC_BITS) + 1;
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(2 ** FRAC_BITS);
  localparam bit HAS_X2 = (OUT_RATE % 2) == 0;
  localparam bit HAS_X4 = (OUT_RATE % 4) == 0;

  logic [63:0]        header;
  logic [2:0]         hdr_idx;
  logic [31:0]        remaining;
  mode_t              rate_mode;
  logic [INC_W-1:0]   increment;
  logic [ACC_W-1:0]   acc;
  logic [15:0]        value;
  logic [CNT_W-1:0]   cnt;
  kind_t              kind_r;
  logic signed [15:0] sample_r;
  logic               last_r;

  logic [15:0]      ver;
  logic [RATE_W-1:0] rate;
  logic [31:0]      count;
  mode_t            hdr_mode;
  logic [31:0]      limit;
  logic [ACC_W-1:0] acc_sum;
  logic             div_done;
  logic [DIV_W-1:0] quotient;
  logic             out_free;

  assign ver   = header[15:0];
  assign rate  = header[31:16];
  assign count = header[63:32];

  // fixed-ratio modes and their length limits
  always_comb begin
    if (32'(rate) == 32'(OUT_RATE)) begin
      hdr_mode = MODE_X1;
    end else if (HAS_X2 && (32'(rate) == 32'(OUT_RATE / 2))) begin
      hdr_mode = MODE_X2;
    end else if (HAS_X4 && (32'(rate) == 32'(OUT_RATE / 4))) begin
      hdr_mode = MODE_X4;
    end else begin
      hdr_mode = MODE_GENERAL;
    end
    case (hdr_mode)
      MODE_X1: limit = LIMIT_X1;
      MODE_X2: limit = LIMIT_X2;
      MODE_X4: limit = LIMIT_X4;
      default: limit = '1;
    endcase
  end

  pcmrc_div #(
    .DIVISOR(OUT_RATE)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rate     (rate),
    .done     (div_done),
    .quotient (quotient)
  );

  assign acc_sum  = acc + ACC_W'(increment);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts              = '0;
    sts.hdr_idx_last = hdr_idx == 3'd7;
    sts.hdr_bad_ver  = ver != VERSION_OK;
    sts.hdr_rate_low = rate < RATE_W'(MIN_RATE);
    sts.hdr_too_long = (hdr_mode != MODE_GENERAL) && (count >= limit);
    sts.count_zero   = count == '0;
    sts.div_done     = div_done;
    sts.mode         = rate_mode;
    sts.acc_ge_one   = acc >= ACC_ONE;
    sts.step_ge_one  = acc_sum >= ACC_ONE;
    sts.cnt_full     = cnt == MAX_FRAMES;
    sts.cnt_last     = cnt == MAX_FRAMES - CNT_W'(1);
    sts.rem_one      = remaining == 32'd1;
    sts.out_free     = out_free;
    case (rate_mode)
      MODE_X1: sts.rep_last = cnt == CNT_W'(0);
      MODE_X2: sts.rep_last = cnt == CNT_W'(1);
      MODE_X4: sts.rep_last = cnt == CNT_W'(3);
      default: sts.rep_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.hdr_first) begin
        hdr_idx <= 3'd1;
      end else if (cmd.hdr_next) begin
        hdr_idx <= hdr_idx + 3'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_first) begin
      header <= {56'd0, data_byte};
    end else if (cmd.hdr_next) begin
      header[{hdr_idx, 3'b000} +: 8] <= data_byte;
    end
    if (cmd.setup) begin
      rate_mode <= hdr_mode;
      increment <= quotient[INC_W-1:0] + INC_W'(1);
      acc       <= '0;
      remaining <= count;
    end else begin
      if (cmd.gen_step) begin
        acc <= acc_sum;
      end else if (cmd.byte_done && (rate_mode == MODE_GENERAL)) begin
        acc <= acc - ACC_ONE;
      end
      if (cmd.byte_done) begin
        remaining <= remaining - 32'd1;
      end
    end
    if (cmd.smp_load) begin
      value <= {data_byte ^ SAMPLE_FLIP, 8'h00};
      cnt   <= '0;
    end else if (cmd.emit && (cmd.emit_kind == KIND_FRAME)) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.emit) begin
      kind_r   <= cmd.emit_kind;
      sample_r <= (cmd.emit_kind == KIND_FRAME) ? value : 16'sd0;
      last_r   <= cmd.emit_last;
    end
  end

  assign out_kind   = kind_r;
  assign out_sample = sample_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

/* rtl/pcmrc_ctrl.sv */
// controller: sequences header capture, decode, divide and frame generation
`default_nettype none

module pcmrc_ctrl import pcmrc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_start,
  output logic         in_ready,
  output cmd_t         cmd,
  input  wire status_t sts
);

  state_t state;
  state_t state_next;
  logic   hdr_err;
  kind_t  hdr_kind;

  assign hdr_err = sts.hdr_bad_ver || sts.hdr_rate_low || sts.hdr_too_long;

  always_comb begin
    if (sts.hdr_bad_ver) begin
      hdr_kind = KIND_BAD_VERSION;
    end else if (sts.hdr_rate_low) begin
      hdr_kind = KIND_RATE_LOW;
    end else if (sts.hdr_too_long) begin
      hdr_kind = KIND_TOO_LONG;
    end else begin
      hdr_kind = KIND_HDR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_start) state_next = S_HEADER;
      end
      S_HEADER: begin
        if (in_valid && !in_start && sts.hdr_idx_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = hdr_err ? S_STATUS : S_DIVIDE;
      end
      S_DIVIDE: begin
        if (sts.div_done) state_next = S_STATUS;
      end
      S_STATUS: begin
        if (sts.out_free) begin
          if (hdr_err) begin
            state_next = S_IDLE;
          end else if (sts.count_zero) begin
            state_next = S_END;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (in_valid) state_next = in_start ? S_HEADER : S_GEN;
      end
      S_GEN: begin
        if (sts.mode == MODE_GENERAL) begin
          if (sts.acc_ge_one) state_next = sts.rem_one ? S_END : S_DATA;
        end else if (sts.out_free && sts.rep_last) begin
          state_next = sts.rem_one ? S_END : S_DATA;
        end
      end
      S_END: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.emit_kind = KIND_FRAME;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.hdr_first = in_valid && in_start;
      end
      S_HEADER: begin
        in_ready      = 1'b1;
        cmd.hdr_first = in_valid && in_start;
        cmd.hdr_next  = in_valid && !in_start;
      end
      S_CHECK: begin
        cmd.div_start = !hdr_err;
      end
      S_DIVIDE: begin
        cmd.setup = sts.div_done;
      end
      S_STATUS: begin
        cmd.emit      = sts.out_free;
        cmd.emit_kind = hdr_kind;
        cmd.emit_last = hdr_err || !sts.count_zero;
      end
      S_DATA: begin
        in_ready      = 1'b1;
        cmd.hdr_first = in_valid && in_start;
        cmd.smp_load  = in_valid && !in_start;
      end
      S_GEN: begin
        if (sts.mode == MODE_GENERAL) begin
          if (sts.acc_ge_one) begin
            cmd.byte_done = 1'b1;
          end else if (sts.cnt_full) begin
            // frame cap reached: keep stepping, drop the frame
            cmd.gen_step = 1'b1;
          end else if (sts.out_free) begin
            cmd.gen_step  = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = (sts.step_ge_one || sts.cnt_last) && !sts.rem_one;
          end
        end else if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = sts.rep_last && !sts.rem_one;
          cmd.byte_done = sts.rep_last;
        end
      end
      S_END: begin
        cmd.emit      = sts.out_free;
        cmd.emit_kind = KIND_END;
        cmd.emit_last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
